// ===== sv/scfc_pkg.sv =====
`timescale 1ns / 1ps
package scfc_pkg;

  localparam int unsigned MaxFrameLimit = 16777216;
  localparam int unsigned CntW = 25;
  localparam int unsigned HdrSize = 128;
  localparam int unsigned TrlSize = 4;
  localparam logic [31:0] Crc32cPoly = 32'h82F63B78;

  localparam logic [1:0] CfgMaxSnapshot = 2'd0;
  localparam logic [1:0] CfgMaxChunk = 2'd1;
  localparam logic [1:0] CfgMaxFrame = 2'd2;

  localparam logic [2:0] StOk = 3'd0;
  localparam logic [2:0] StLimits = 3'd1;
  localparam logic [2:0] StSize = 3'd2;
  localparam logic [2:0] StHdrCrc = 3'd3;
  localparam logic [2:0] StVersion = 3'd4;
  localparam logic [2:0] StFields = 3'd5;
  localparam logic [2:0] StSemantic = 3'd6;

  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte;
    logic       frame_end;
    logic       size_bad;
    logic       hdr_crc_bad;
    logic       version_bad;
    logic       fields_bad;
    logic       sem_bad;
    logic [CntW-1:0] psize;
  } scfc_work_t;

  function automatic logic [31:0] crc_byte(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ Crc32cPoly) : (r >> 1);
    end
    return r;
  endfunction

endpackage

// ===== sv/scfc_front.sv =====
`timescale 1ns / 1ps
module scfc_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    frame_byte_i,
  input  logic                          is_last_i,
  input  logic [63:0]                   max_snapshot_i,
  input  logic [24:0]                   max_chunk_i,
  input  logic [24:0]                   max_frame_i,
  output logic                          wk_valid_o,
  input  logic                          wk_ready_i,
  output scfc_pkg::scfc_work_t          wk_o,
  output logic [1023:0]                 hdr_o
);
  import scfc_pkg::*;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [1023:0] hdr_q;
  logic [7:0] dly_q [TrlSize];
  logic [1:0] pos_q;
  logic [31:0] hcrc_q, pcrc_q, fcrc_q, hcrc_d, pcrc_d, fcrc_d;
  logic wv_q;
  scfc_work_t w_q, w_d;
  logic acc;
  logic [7:0] leaving;
  logic [31:0] trailer;
  logic [1023:0] hn;
  logic [CntW-1:0] size;

  assign in_ready_o = !wv_q || wk_ready_i;
  assign acc = in_valid_i && in_ready_o;
  assign leaving = dly_q[pos_q];
  assign size = cnt_q + 1'b1;

  function automatic logic [63:0] le(logic [1023:0] h, int unsigned off);
    return h[off*8 +: 64];
  endfunction

  always_comb begin
    hn = hdr_q;
    hcrc_d = hcrc_q;
    if (cnt_q < CntW'(HdrSize)) begin
      hn[cnt_q[6:0]*8 +: 8] = frame_byte_i;
      hcrc_d = crc_byte(hcrc_q, (cnt_q >= 120 && cnt_q < 124) ? 8'd0 : frame_byte_i);
    end
    fcrc_d = fcrc_q;
    pcrc_d = pcrc_q;
    w_d = '0;
    if (cnt_q >= CntW'(TrlSize)) begin
      fcrc_d = crc_byte(fcrc_q, leaving);
      if (cnt_q >= CntW'(HdrSize + TrlSize)) begin
        pcrc_d = crc_byte(pcrc_q, leaving);
        w_d.data_valid = 1'b1;
        w_d.data_byte = leaving;
      end
    end
    trailer = {frame_byte_i, dly_q[pos_q + 2'd3], dly_q[pos_q + 2'd2], dly_q[pos_q + 2'd1]};
    cnt_d = (cnt_q < CntW'(MaxFrameLimit + 1)) ? cnt_q + 1'b1 : cnt_q;
    w_d.frame_end = is_last_i;
    w_d.psize = hn[112*8 +: 25];
    w_d.size_bad = (cnt_q == CntW'(MaxFrameLimit)) || (cnt_q > CntW'(MaxFrameLimit))
                   || size < 25'd133 || size > max_frame_i;
    w_d.hdr_crc_bad = ~hcrc_q != hdr_q[120*8 +: 32];
    w_d.version_bad = le(hdr_q, 0) != 64'h004B_4843_4D52_4843
                      || hdr_q[8*8 +: 16] != 16'd1 || hdr_q[10*8 +: 16] != 16'd0;
    w_d.fields_bad = hdr_q[12*8 +: 32] != 32'd128 || le(hdr_q, 16) != 64'(size)
                     || (cnt_q >= CntW'(MaxFrameLimit))
                     || hdr_q[100*8 +: 32] != 32'd0 || hdr_q[124*8 +: 32] != 32'd0
                     || hdr_q[112*8 +: 32] == 32'd0
                     || hdr_q[112*8 +: 32] > {7'd0, max_chunk_i}
                     || hdr_q[112*8 +: 32] != 32'(size) - 32'd132;
    w_d.sem_bad = hdr_q[24*8 +: 128] == '0 || le(hdr_q, 40) == '0 || le(hdr_q, 48) == '0
                  || le(hdr_q, 56) == '0 || le(hdr_q, 48) == le(hdr_q, 56)
                  || le(hdr_q, 64) == '0 || le(hdr_q, 72) == '0 || le(hdr_q, 80) == '0
                  || le(hdr_q, 88) == '0 || le(hdr_q, 88) > max_snapshot_i
                  || le(hdr_q, 104) > le(hdr_q, 88)
                  || 64'(hdr_q[112*8 +: 32]) > le(hdr_q, 88) - le(hdr_q, 104)
                  || ~pcrc_d != hdr_q[116*8 +: 32] || ~fcrc_d != trailer;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      pos_q <= '0;
      hcrc_q <= '1;
      pcrc_q <= '1;
      fcrc_q <= '1;
      wv_q <= 1'b0;
    end else begin
      if (acc) begin
        wv_q <= w_d.data_valid || is_last_i;
        if (is_last_i) begin
          cnt_q <= '0;
          pos_q <= '0;
          hcrc_q <= '1;
          pcrc_q <= '1;
          fcrc_q <= '1;
        end else begin
          cnt_q <= cnt_d;
          pos_q <= pos_q + 2'd1;
          hcrc_q <= hcrc_d;
          pcrc_q <= pcrc_d;
          fcrc_q <= fcrc_d;
        end
      end else if (wk_ready_i) begin
        wv_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      hdr_q <= hn;
      dly_q[pos_q] <= frame_byte_i;
      w_q <= w_d;
    end
  end

  assign wk_valid_o = wv_q;
  assign wk_o = w_q;
  assign hdr_o = hdr_q;
endmodule

// ===== sv/scfc_back.sv =====
`timescale 1ns / 1ps
module scfc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wk_valid_i,
  output logic                 wk_ready_o,
  input  scfc_pkg::scfc_work_t wk_i,
  input  logic [1023:0]        hdr_i,
  input  logic                 limits_bad_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 data_valid_o,
  output logic [7:0]           data_byte_o,
  output logic                 frame_end_o,
  output logic [2:0]           status_o,
  output logic [63:0]          chunk_offset_o,
  output logic [24:0]          payload_length_o,
  output logic [63:0]          snapshot_total_o,
  output logic [63:0]          placement_epoch_o,
  output logic [63:0]          source_node_o,
  output logic [63:0]          target_node_o,
  output logic [63:0]          applied_index_o,
  output logic [63:0]          applied_term_o
);
  import scfc_pkg::*;

  logic ov_q;
  logic [2:0] st;
  logic dec;

  assign wk_ready_o = !ov_q || out_ready_i;

  always_comb begin
    if (limits_bad_i) st = StLimits;
    else if (wk_i.size_bad) st = StSize;
    else if (wk_i.hdr_crc_bad) st = StHdrCrc;
    else if (wk_i.version_bad) st = StVersion;
    else if (wk_i.fields_bad) st = StFields;
    else if (wk_i.sem_bad) st = StSemantic;
    else st = StOk;
    dec = wk_i.frame_end && st >= StHdrCrc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (wk_ready_o) ov_q <= wk_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (wk_ready_o && wk_valid_i) begin
      data_valid_o <= wk_i.data_valid;
      data_byte_o <= wk_i.data_byte;
      frame_end_o <= wk_i.frame_end;
      status_o <= wk_i.frame_end ? st : StOk;
      chunk_offset_o <= dec ? hdr_i[104*8 +: 64] : '0;
      payload_length_o <= dec ? wk_i.psize : '0;
      snapshot_total_o <= dec ? hdr_i[88*8 +: 64] : '0;
      placement_epoch_o <= dec ? hdr_i[40*8 +: 64] : '0;
      source_node_o <= dec ? hdr_i[48*8 +: 64] : '0;
      target_node_o <= dec ? hdr_i[56*8 +: 64] : '0;
      applied_index_o <= dec ? hdr_i[72*8 +: 64] : '0;
      applied_term_o <= dec ? hdr_i[80*8 +: 64] : '0;
    end
  end

  assign out_valid_o = ov_q;
endmodule

// ===== sv/snapshot_chunk_frame_checker.sv =====
`timescale 1ns / 1ps
// channel | dir | handshake             | payload
// in      | in  | in_valid_i/in_ready_o | frame_byte_i, is_last_i
// out     | out | out_valid_o/out_ready_i | data/verdict fields
// cfg     | in  | cfg_we_i              | cfg_idx_i, cfg_data_i
// One word per cycle while in_ready_o is high; CRC updates and header capture in the front stage.
// Checks are evaluated in front, priority encoded in the back stage.
// Result reaches the outputs through two register stages (front work word, back output registers).
// Reset restores config limits and per-frame counters and CRCs; stalls hold each stage.
module snapshot_chunk_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  frame_byte_i,
  input  logic        is_last_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        data_valid_o,
  output logic [7:0]  data_byte_o,
  output logic        frame_end_o,
  output logic [2:0]  status_o,
  output logic [63:0] chunk_offset_o,
  output logic [24:0] payload_length_o,
  output logic [63:0] snapshot_total_o,
  output logic [63:0] placement_epoch_o,
  output logic [63:0] source_node_o,
  output logic [63:0] target_node_o,
  output logic [63:0] applied_index_o,
  output logic [63:0] applied_term_o
);
  import scfc_pkg::*;

  logic [63:0] msnap_q;
  logic [24:0] mchunk_q, mframe_q;
  logic lim_q;
  logic wv, wr;
  scfc_work_t wk;
  logic [1023:0] hdr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msnap_q <= '1;
      mchunk_q <= 25'd16777084;
      mframe_q <= 25'd16777216;
      lim_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgMaxSnapshot: msnap_q <= cfg_data_i;
          CfgMaxChunk: mchunk_q <= cfg_data_i[24:0];
          CfgMaxFrame: mframe_q <= cfg_data_i[24:0];
          default: ;
        endcase
      end
      lim_q <= msnap_q == '0 || mchunk_q == '0 || 64'(mchunk_q) > msnap_q
               || mframe_q < 25'd133 || mframe_q > 25'(MaxFrameLimit)
               || mchunk_q > mframe_q - 25'd132;
    end
  end

  scfc_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .frame_byte_i, .is_last_i,
    .max_snapshot_i(msnap_q), .max_chunk_i(mchunk_q), .max_frame_i(mframe_q),
    .wk_valid_o(wv), .wk_ready_i(wr), .wk_o(wk), .hdr_o(hdr)
  );

  scfc_back u_back (
    .clk_i, .rst_ni, .wk_valid_i(wv), .wk_ready_o(wr), .wk_i(wk), .hdr_i(hdr),
    .limits_bad_i(lim_q), .out_valid_o, .out_ready_i, .data_valid_o, .data_byte_o,
    .frame_end_o, .status_o, .chunk_offset_o, .payload_length_o, .snapshot_total_o,
    .placement_epoch_o, .source_node_o, .target_node_o, .applied_index_o,
    .applied_term_o
  );
endmodule

// ===== tb/snapshot_chunk_frame_checker_tb.sv =====
`timescale 1ns / 1ps
module snapshot_chunk_frame_checker_tb;
  import scfc_pkg::*;

  localparam logic [1:0] CfgUnused = 2'd3;

  typedef enum int {
    MutNone, MutMagic, MutVersion, MutHdrLen, MutSrcDst, MutTablet, MutOffset,
    MutTotalZero, MutPayCrc, MutTrailer, MutHdrCrc, MutRandHdr, MutRandByte, MutLength
  } mutation_e;

  typedef struct packed {
    logic        dv;
    logic [7:0]  db;
    logic        fe;
    logic [2:0]  st;
    logic [63:0] off;
    logic [24:0] plen;
    logic [63:0] tot;
    logic [63:0] ep;
    logic [63:0] src;
    logic [63:0] dst;
    logic [63:0] idx;
    logic [63:0] term;
  } frame_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  frame_byte_i = '0;
  logic        is_last_i = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [63:0] cfg_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        data_valid_o;
  logic [7:0]  data_byte_o;
  logic        frame_end_o;
  logic [2:0]  status_o;
  logic [63:0] chunk_offset_o;
  logic [24:0] payload_length_o;
  logic [63:0] snapshot_total_o;
  logic [63:0] placement_epoch_o;
  logic [63:0] source_node_o;
  logic [63:0] target_node_o;
  logic [63:0] applied_index_o;
  logic [63:0] applied_term_o;

  snapshot_chunk_frame_checker i_dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state
  logic [63:0] lim_snap, lim_chunk, lim_frame;
  longint unsigned rx_count;
  logic [7:0]  hdr_mem [128];
  logic [7:0]  dly_mem [4];
  int unsigned dly_wr;
  logic [31:0] hcrc, pcrc, fcrc;

  frame_res_t  result_q[$];
  int          fail_cnt = 0;
  int          words_sent = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;

  logic [7:0]  bld_hdr [128];
  logic [7:0]  frame_q[$];

  function automatic logic [31:0] crc32c_next(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ 32'h82F63B78) : (r >> 1);
    return r;
  endfunction

  function automatic logic [63:0] hdr_get(int off, int len);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < len; i++) v[8*i +: 8] = hdr_mem[off + i];
    return v;
  endfunction

  function automatic void frame_clear();
    rx_count = 0;
    dly_wr = 0;
    hcrc = '1;
    pcrc = '1;
    fcrc = '1;
  endfunction

  function automatic logic [2:0] judge(longint unsigned fsize, logic [31:0] trl);
    logic [63:0] ps, tot, off, src, dst;
    logic nil;
    if (lim_snap == 0 || lim_chunk == 0 || lim_chunk > lim_snap || lim_frame < 133 ||
        lim_frame > MaxFrameLimit || lim_chunk > lim_frame - 132)
      return StLimits;
    if (fsize < 133 || fsize > lim_frame) return StSize;
    if (~hcrc != 32'(hdr_get(120, 4))) return StHdrCrc;
    if (hdr_get(0, 8) != 64'h004B4843_4D524843 || hdr_get(8, 2) != 1 ||
        hdr_get(10, 2) != 0)
      return StVersion;
    ps = hdr_get(112, 4);
    if (hdr_get(12, 4) != 128 || hdr_get(16, 8) != fsize || hdr_get(100, 4) != 0 ||
        hdr_get(124, 4) != 0 || ps == 0 || ps > lim_chunk || ps != fsize - 132)
      return StFields;
    nil = 1'b1;
    for (int i = 24; i < 40; i++) if (hdr_mem[i] != 0) nil = 1'b0;
    tot = hdr_get(88, 8);
    off = hdr_get(104, 8);
    src = hdr_get(48, 8);
    dst = hdr_get(56, 8);
    if (nil || hdr_get(40, 8) == 0 || src == 0 || dst == 0 || src == dst ||
        hdr_get(64, 8) == 0 || hdr_get(72, 8) == 0 || hdr_get(80, 8) == 0 ||
        tot == 0 || tot > lim_snap || off > tot || ps > tot - off ||
        ~pcrc != 32'(hdr_get(116, 4)) || ~fcrc != trl)
      return StSemantic;
    return StOk;
  endfunction

  function automatic void absorb_word(logic [7:0] b, logic last);
    frame_res_t r;
    logic prod;
    logic [7:0] lv;
    logic [31:0] trl;
    longint unsigned n;
    r = '0;
    prod = 1'b0;
    n = rx_count;
    if (n < 128) begin
      hdr_mem[n] = b;
      hcrc = crc32c_next(hcrc, (n >= 120 && n < 124) ? 8'd0 : b);
    end
    lv = dly_mem[dly_wr];
    if (n >= 4) begin
      fcrc = crc32c_next(fcrc, lv);
      if (n >= 132) begin
        pcrc = crc32c_next(pcrc, lv);
        r.dv = 1'b1;
        r.db = lv;
        prod = 1'b1;
      end
    end
    dly_mem[dly_wr] = b;
    dly_wr = (dly_wr + 1) % 4;
    if (rx_count < longint'(MaxFrameLimit) + 1) rx_count++;
    if (last) begin
      for (int i = 0; i < 4; i++) trl[8*i +: 8] = dly_mem[(dly_wr + i) % 4];
      r.fe = 1'b1;
      r.st = judge(n + 1, trl);
      if (r.st >= StHdrCrc) begin
        r.off = hdr_get(104, 8);
        r.plen = 25'(hdr_get(112, 4));
        r.tot = hdr_get(88, 8);
        r.ep = hdr_get(40, 8);
        r.src = hdr_get(48, 8);
        r.dst = hdr_get(56, 8);
        r.idx = hdr_get(72, 8);
        r.term = hdr_get(80, 8);
      end
      frame_clear();
      prod = 1'b1;
    end
    if (prod) result_q.push_back(r);
  endfunction

  task automatic send_word(logic [7:0] b, logic last);
    int gap;
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(4, 1);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    frame_byte_i <= b;
    is_last_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    absorb_word(b, last);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [63:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgMaxSnapshot: lim_snap = data;
      CfgMaxChunk: lim_chunk = data[24:0];
      CfgMaxFrame: lim_frame = data[24:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (result_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic put_le(int off, int len, logic [63:0] v);
    for (int i = 0; i < len; i++) bld_hdr[off + i] = v[8*i +: 8];
  endtask

  function automatic logic [63:0] rand_nz64();
    logic [63:0] v;
    v = {$urandom, $urandom};
    if (v == 0) v = 1;
    return v;
  endfunction

  task automatic build_frame(int psize, mutation_e m);
    logic [63:0] tot, off, src, dst;
    logic [31:0] c;
    logic [7:0] pay[$];
    int pos;
    for (int i = 0; i < 128; i++) bld_hdr[i] = '0;
    put_le(0, 8, 64'h004B4843_4D524843);
    put_le(8, 2, 1);
    put_le(12, 4, 128);
    put_le(16, 8, psize + 132);
    for (int i = 24; i < 40; i++) bld_hdr[i] = $urandom;
    if (bld_hdr[24] == 0) bld_hdr[24] = 8'h5A;
    src = rand_nz64();
    dst = rand_nz64();
    if (dst == src) dst = ~src;
    put_le(40, 8, rand_nz64());
    put_le(48, 8, src);
    put_le(56, 8, dst);
    put_le(64, 8, rand_nz64());
    put_le(72, 8, rand_nz64());
    put_le(80, 8, rand_nz64());
    if ($urandom_range(1)) begin
      tot = psize + $urandom_range(3000);
      off = $urandom_range(tot - psize);
    end else begin
      tot = rand_nz64() | 64'h8000_0000_0000_0000;
      off = tot - psize - {32'd0, $urandom};
    end
    put_le(88, 8, tot);
    put_le(104, 8, off);
    put_le(112, 4, psize);
    case (m)
      MutMagic: bld_hdr[$urandom_range(7)] ^= 8'h01 << $urandom_range(7);
      MutVersion: bld_hdr[$urandom_range(11, 8)] ^= 8'h01 << $urandom_range(7);
      MutHdrLen: bld_hdr[$urandom_range(15, 12)] ^= 8'h01 << $urandom_range(7);
      MutSrcDst: put_le(56, 8, src);
      MutTablet: for (int i = 24; i < 40; i++) bld_hdr[i] = '0;
      MutOffset: put_le(104, 8, tot + 1 + $urandom_range(5));
      MutTotalZero: put_le(88, 8, 0);
      MutRandHdr: bld_hdr[$urandom_range(115)] = $urandom;
      default: ;
    endcase
    c = '1;
    for (int i = 0; i < psize; i++) begin
      pay.push_back($urandom);
      c = crc32c_next(c, pay[i]);
    end
    put_le(116, 4, ~c ^ ((m == MutPayCrc) ? 32'h1 << $urandom_range(31) : 32'h0));
    c = '1;
    for (int i = 0; i < 128; i++) c = crc32c_next(c, bld_hdr[i]);
    put_le(120, 4, ~c ^ ((m == MutHdrCrc) ? 32'h1 << $urandom_range(31) : 32'h0));
    frame_q.delete();
    c = '1;
    for (int i = 0; i < 128; i++) frame_q.push_back(bld_hdr[i]);
    foreach (pay[i]) frame_q.push_back(pay[i]);
    foreach (frame_q[i]) c = crc32c_next(c, frame_q[i]);
    c = ~c ^ ((m == MutTrailer) ? 32'h1 << $urandom_range(31) : 32'h0);
    for (int i = 0; i < 4; i++) frame_q.push_back(c[8*i +: 8]);
    if (m == MutRandByte) begin
      pos = $urandom_range(frame_q.size() - 1);
      frame_q[pos] ^= 8'h01 << $urandom_range(7);
    end
    if (m == MutLength) frame_q.insert(128, $urandom);
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_word(frame_q[i], i == frame_q.size() - 1);
  endtask

  task automatic send_noise(int len);
    frame_q.delete();
    for (int i = 0; i < len; i++) frame_q.push_back($urandom);
    send_frame();
  endtask

  task automatic restore_limits();
    cfg_write(CfgMaxSnapshot, '1);
    cfg_write(CfgMaxChunk, 16777084);
    cfg_write(CfgMaxFrame, MaxFrameLimit);
  endtask

  task automatic test_limits();
    logic [63:0] snaps [6] = '{0, '1, '1, '1, '1, 64'd100};
    logic [63:0] chunks[6] = '{16777084, 0, 16777084, 16777085, 16777084, 200};
    logic [63:0] frames[6] = '{MaxFrameLimit, MaxFrameLimit, 132, MaxFrameLimit,
                               64'hFFFF_FFFF_FFFF_FFFF, MaxFrameLimit};
    for (int k = 0; k < 6; k++) begin
      cfg_write(CfgMaxSnapshot, snaps[k]);
      cfg_write(CfgMaxChunk, chunks[k]);
      cfg_write(CfgMaxFrame, frames[k]);
      send_noise(1);
      drain();
    end
    cfg_write(CfgUnused, '0);
    restore_limits();
    cfg_write(CfgMaxChunk, 1);
    cfg_write(CfgMaxFrame, 133);
    build_frame(1, MutNone);
    send_frame();
    drain();
    restore_limits();
  endtask

  task automatic test_sizes();
    send_noise(1);
    send_noise(3);
    send_noise(132);
    drain();
    cfg_write(CfgMaxChunk, 8);
    cfg_write(CfgMaxFrame, 140);
    build_frame(8, MutNone);
    send_frame();
    build_frame(9, MutNone);
    send_frame();
    drain();
    restore_limits();
  endtask

  task automatic test_header_checks();
    for (int m = MutMagic; m <= MutLength; m++) begin
      build_frame($urandom_range(6, 1), mutation_e'(m));
      send_frame();
    end
    drain();
  endtask

  task automatic test_random();
    int idle_tab [4] = '{0, 57, 0, 10};
    int stall_tab[4] = '{0, 0, 57, 10};
    int r, ps, target;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        1: begin
          cfg_write(CfgMaxSnapshot, $urandom_range(5000, 500));
          cfg_write(CfgMaxChunk, 200);
        end
        2: begin
          cfg_write(CfgMaxSnapshot, '1);
          cfg_write(CfgMaxChunk, 8);
          cfg_write(CfgMaxFrame, 140);
        end
        3: restore_limits();
        default: ;
      endcase
      idle_pct = idle_tab[ph];
      stall_pct = stall_tab[ph];
      target = words_sent + 100;
      while (words_sent < target) begin
        r = $urandom_range(99);
        ps = ($urandom_range(19) == 0) ? $urandom_range(200, 1) : $urandom_range(16, 1);
        if (r < 72) begin
          build_frame(ps, MutNone);
          send_frame();
        end else if (r < 92) begin
          build_frame(ps, mutation_e'($urandom_range(MutLength, MutMagic)));
          send_frame();
        end else begin
          send_noise($urandom_range(150, 1));
        end
      end
      drain();
    end
  endtask

  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk_i) begin
    frame_res_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{data_valid_o, data_byte_o, frame_end_o, status_o, chunk_offset_o,
              payload_length_o, snapshot_total_o, placement_epoch_o, source_node_o,
              target_node_o, applied_index_o, applied_term_o};
      if (result_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10) $display("unexpected word: dv=%b db=%h fe=%b st=%0d",
                                     got.dv, got.db, got.fe, got.st);
      end else begin
        want = result_q.pop_front();
        if (got.dv !== want.dv || got.db !== want.db || got.fe !== want.fe ||
            got.st !== want.st || got.off !== want.off || got.plen !== want.plen ||
            got.tot !== want.tot || got.ep !== want.ep || got.src !== want.src ||
            got.dst !== want.dst || got.idx !== want.idx || got.term !== want.term) begin
          fail_cnt++;
          if (fail_cnt <= 10) begin
            $display("mismatch exp: dv=%b db=%h fe=%b st=%0d off=%h len=%h tot=%h",
                     want.dv, want.db, want.fe, want.st, want.off, want.plen, want.tot);
            $display("  exp ids: ep=%h src=%h dst=%h idx=%h term=%h",
                     want.ep, want.src, want.dst, want.idx, want.term);
            $display("mismatch act: dv=%b db=%h fe=%b st=%0d off=%h len=%h tot=%h",
                     got.dv, got.db, got.fe, got.st, got.off, got.plen, got.tot);
            $display("  act ids: ep=%h src=%h dst=%h idx=%h term=%h",
                     got.ep, got.src, got.dst, got.idx, got.term);
          end
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("** snapshot_chunk_frame_checker: FAILED **");
    $finish;
  end

  initial begin
    lim_snap = '1;
    lim_chunk = 16777084;
    lim_frame = MaxFrameLimit;
    for (int i = 0; i < 128; i++) hdr_mem[i] = '0;
    for (int i = 0; i < 4; i++) dly_mem[i] = '0;
    frame_clear();
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_limits();
    test_sizes();
    test_header_checks();
    test_random();
    drain();
    repeat (10) @(negedge clk_i);
    if (fail_cnt == 0 && result_q.size() == 0) begin
      $display("** snapshot_chunk_frame_checker: PASSED **");
    end else begin
      $display("** snapshot_chunk_frame_checker: FAILED **");
    end
    $finish;
  end

endmodule
